// File: rtl/core/ps2kd_pkg.sv
// Types, codes and lookup helpers for the PS/2 set 1 key decoder.
package ps2kd_pkg;

  // Sequence decode modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_E0     = 2'd1,
    MODE_PAUSE  = 2'd2,
    MODE_PRINT  = 2'd3
  } decode_mode_t;

  // Event kinds carried on tuser
  typedef enum logic {
    EVT_KEY = 1'b0,
    EVT_LED = 1'b1
  } event_kind_t;

  localparam int SEQ_W = 40;   // five buffered bytes plus the incoming byte cover the longest sequence

  localparam logic [7:0] BYTE_ACK = 8'hFA;
  localparam logic [7:0] BYTE_E0  = 8'hE0;
  localparam logic [7:0] BYTE_E1  = 8'hE1;

  localparam logic [47:0] SEQ_PAUSE       = 48'hE11D45E19DC5;
  localparam logic [31:0] SEQ_PRINT_BREAK = 32'hE0B7E0AA;
  localparam logic [15:0] SEQ_PRINT_MAKE1 = 16'hE02A;
  localparam logic [15:0] SEQ_PRINT_BRK1  = 16'hE0B7;
  localparam logic [15:0] SEQ_RALT_MAKE   = 16'hE038;
  localparam logic [15:0] SEQ_RCTRL_MAKE  = 16'hE01D;
  localparam logic [15:0] SEQ_RALT_BRK    = 16'hE0B8;
  localparam logic [15:0] SEQ_RCTRL_BRK   = 16'hE09D;
  localparam logic [15:0] SEQ_INSERT_MAKE = 16'hE052;

  // Plain (un-prefixed) codes
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
  localparam logic [7:0] SC_SCROLL_MAKE  = 8'h46;
  localparam logic [7:0] SC_CAPS_BRK     = 8'hBA;
  localparam logic [7:0] SC_NUM_BRK      = 8'hC5;
  localparam logic [7:0] SC_SCROLL_BRK   = 8'hC6;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BRK   = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BRK   = 8'hB6;
  localparam logic [7:0] SC_LCTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BRK    = 8'h9D;

  localparam logic [6:0] KEY_PRINT = 7'h59;
  localparam logic [6:0] KEY_PAUSE = 7'h5A;
  localparam logic [6:0] KEY_PAD_LO = 7'h47;
  localparam logic [6:0] KEY_PAD_HI = 7'h51;

  localparam logic [1:0] VAR_BASE    = 2'd0;
  localparam logic [1:0] VAR_SHIFTED = 2'd1;
  localparam logic [1:0] VAR_KEYPAD  = 2'd2;

  // Modifier word bit positions
  localparam int MF_LSHIFT = 0;
  localparam int MF_RSHIFT = 1;
  localparam int MF_LCTRL  = 2;
  localparam int MF_RCTRL  = 3;
  localparam int MF_RALT   = 4;
  localparam int MF_CAPS   = 5;
  localparam int MF_NUM    = 6;
  localparam int MF_SCROLL = 7;
  localparam int MF_INSERT = 8;

  localparam logic [8:0] MF_RESET = 9'h040;

  // True for key indices that have a key table entry
  function automatic logic has_entry(input logic [6:0] idx);
    logic ok;
    ok = 1'b1;
    if (idx == 7'h00 || idx > KEY_PAUSE) ok = 1'b0;
    if (idx == 7'h4C) ok = 1'b0;
    if (idx >= 7'h54 && idx <= 7'h56) ok = 1'b0;
    return ok;
  endfunction

endpackage

// File: rtl/core/ps2_scan_set1_key_decoder.sv
// PS/2 scan code set 1 key decoder: sequence tracking, modifiers and event output.
//
// Decodes one raw set 1 keyboard byte per transfer. Acknowledge bytes are
// dropped; E0 prefixes, the six-byte Pause and four-byte Print Screen
// sequences, shift/ctrl/right-alt and the caps/num/scroll/insert toggles are
// tracked internally. A key release produces a key event (tuser = 0) with key
// index, variant and modifier word; a lock or insert toggle produces an LED
// event (tuser = 1). Decode state updates at the input transfer and the result
// lands in the output register on the same edge, so a new byte is taken every
// cycle while the output register is empty or being drained. Output valid is
// registered and rises in the cycle after the input transfer.
module ps2_scan_set1_key_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] key_index, [8:7] key_variant,
                                      // [17:9] modifier_word, [20:18] led_bits,
                                      // [23:21] zero
  output logic        m_axis_tuser    // [0] event_kind
);
  import ps2kd_pkg::*;

  decode_mode_t     mode, mode_next;
  logic [SEQ_W-1:0] seq_buf, seq_buf_next;
  logic [2:0]       seq_cnt, seq_cnt_next;
  logic [8:0]       mods, mods_next;
  logic             insert_skip, insert_skip_next;

  logic             out_valid;
  logic             out_kind;
  logic [6:0]       out_key;
  logic [1:0]       out_variant;
  logic [8:0]       out_mods;
  logic [2:0]       out_led;

  logic             in_xfer;
  logic [7:0]       b;
  logic [15:0]      seq16;
  logic [31:0]      seq32;
  logic [47:0]      seq48;
  logic             key_req, led_req, pad_ok;
  logic [6:0]       key_idx;
  logic             emit, emit_kind;
  logic [1:0]       variant;
  logic [2:0]       led_val;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign seq16         = {seq_buf[7:0], b};
  assign seq32         = {seq_buf[23:0], b};
  assign seq48         = {seq_buf, b};

  always_comb begin
    mode_next        = mode;
    seq_buf_next     = seq_buf;
    seq_cnt_next     = seq_cnt;
    mods_next        = mods;
    insert_skip_next = insert_skip;
    key_req          = 1'b0;
    led_req          = 1'b0;
    pad_ok           = 1'b0;
    key_idx          = b[6:0];

    if (b == BYTE_ACK) begin
      // acknowledge: nothing to do
    end else if (seq_cnt == 3'd0 && (b == BYTE_E1 || b == BYTE_E0)) begin
      seq_buf_next = {{(SEQ_W-8){1'b0}}, b};
      seq_cnt_next = 3'd1;
      mode_next    = (b == BYTE_E1) ? MODE_PAUSE : MODE_E0;
    end else begin
      unique case (mode)
        MODE_PAUSE: begin
          if (seq_cnt < 3'd5) begin
            seq_buf_next = {seq_buf[SEQ_W-9:0], b};
            seq_cnt_next = seq_cnt + 3'd1;
          end else begin
            mode_next    = MODE_NORMAL;
            seq_buf_next = '0;
            seq_cnt_next = 3'd0;
            if (seq48 == SEQ_PAUSE) begin
              key_req = 1'b1;
              key_idx = KEY_PAUSE;
            end
          end
        end
        MODE_E0: begin
          if (seq16 == SEQ_PRINT_MAKE1 || seq16 == SEQ_PRINT_BRK1) begin
            seq_buf_next = {seq_buf[SEQ_W-9:0], b};
            seq_cnt_next = seq_cnt + 3'd1;
            mode_next    = MODE_PRINT;
          end else begin
            mode_next    = MODE_NORMAL;
            seq_buf_next = '0;
            seq_cnt_next = 3'd0;
            if (seq16 == SEQ_RALT_MAKE) begin
              mods_next[MF_RALT] = 1'b1;
            end else if (seq16 == SEQ_RCTRL_MAKE) begin
              mods_next[MF_RCTRL] = 1'b1;
            end else if (seq16 == SEQ_RALT_BRK) begin
              mods_next[MF_RALT] = 1'b0;
            end else if (seq16 == SEQ_RCTRL_BRK) begin
              mods_next[MF_RCTRL] = 1'b0;
            end else if (seq16 == SEQ_INSERT_MAKE) begin
              mods_next[MF_INSERT] = !mods[MF_INSERT];
              insert_skip_next     = 1'b1;
              led_req              = 1'b1;
            end else begin
              key_req = b[7];
            end
          end
        end
        MODE_PRINT: begin
          if (seq_cnt < 3'd3) begin
            seq_buf_next = {seq_buf[SEQ_W-9:0], b};
            seq_cnt_next = seq_cnt + 3'd1;
          end else begin
            mode_next    = MODE_NORMAL;
            seq_buf_next = '0;
            seq_cnt_next = 3'd0;
            if (seq32 == SEQ_PRINT_BREAK) begin
              key_req = 1'b1;
              key_idx = KEY_PRINT;
            end
          end
        end
        MODE_NORMAL: begin
          unique case (b)
            SC_CAPS_MAKE, SC_NUM_MAKE, SC_SCROLL_MAKE: begin
              // locks toggle on release
            end
            SC_CAPS_BRK: begin
              mods_next[MF_CAPS] = !mods[MF_CAPS];
              led_req            = 1'b1;
            end
            SC_NUM_BRK: begin
              mods_next[MF_NUM] = !mods[MF_NUM];
              led_req           = 1'b1;
            end
            SC_SCROLL_BRK: begin
              mods_next[MF_SCROLL] = !mods[MF_SCROLL];
              led_req              = 1'b1;
            end
            SC_LSHIFT_MAKE: mods_next[MF_LSHIFT] = 1'b1;
            SC_LSHIFT_BRK:  mods_next[MF_LSHIFT] = 1'b0;
            SC_RSHIFT_MAKE: mods_next[MF_RSHIFT] = 1'b1;
            SC_RSHIFT_BRK:  mods_next[MF_RSHIFT] = 1'b0;
            SC_LCTRL_MAKE:  mods_next[MF_LCTRL]  = 1'b1;
            SC_LCTRL_BRK:   mods_next[MF_LCTRL]  = 1'b0;
            default: begin
              key_req = b[7];
              pad_ok  = 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // Event formation from the updated modifier word
    emit      = 1'b0;
    emit_kind = EVT_KEY;
    variant   = (mods_next[MF_CAPS] != (mods_next[MF_LSHIFT] || mods_next[MF_RSHIFT]))
                ? VAR_SHIFTED : VAR_BASE;
    led_val   = {mods_next[MF_CAPS], mods_next[MF_NUM], mods_next[MF_SCROLL]};
    if (led_req) begin
      emit      = 1'b1;
      emit_kind = EVT_LED;
    end else if (key_req) begin
      if (insert_skip) begin
        // the next key release after an Insert make is swallowed
        insert_skip_next = 1'b0;
      end else if (pad_ok && mods_next[MF_NUM] &&
                   key_idx >= KEY_PAD_LO && key_idx <= KEY_PAD_HI) begin
        emit    = 1'b1;
        variant = VAR_KEYPAD;
      end else if (has_entry(key_idx)) begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      seq_buf     <= '0;
      seq_cnt     <= 3'd0;
      mods        <= MF_RESET;
      insert_skip <= 1'b0;
    end else if (in_xfer) begin
      mode        <= mode_next;
      seq_buf     <= seq_buf_next;
      seq_cnt     <= seq_cnt_next;
      mods        <= mods_next;
      insert_skip <= insert_skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_kind    <= emit_kind;
      out_key     <= (emit_kind == EVT_LED) ? 7'd0 : key_idx;
      out_variant <= (emit_kind == EVT_LED) ? VAR_BASE : variant;
      out_mods    <= mods_next;
      out_led     <= (emit_kind == EVT_LED) ? led_val : 3'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_led, out_mods, out_variant, out_key};
  assign m_axis_tuser  = out_kind;

endmodule
